### hw/rtl/pcm_cvt_pkg.sv
// Package: format codes and float conversion helpers for the PCM converter.
`default_nettype none
package pcm_cvt_pkg;

  typedef enum logic [1:0] {
    FMT_PCM8  = 2'd0,
    FMT_PCM16 = 2'd1,
    FMT_PCM24 = 2'd2,
    FMT_FLOAT = 2'd3
  } fmt_e;

  typedef enum logic {
    REG_SOURCE_FORMAT = 1'b0,
    REG_TARGET_FORMAT = 1'b1
  } reg_idx_e;

  localparam logic [31:0] PosFull = 32'h7FFF_FFFF;
  localparam logic [31:0] NegFull = 32'h8000_0001;

  // Float to 32-bit word: floor(f * 2^31), saturated, NaN gives zero.
  function automatic logic [31:0] float_to_word(input logic [31:0] bits);
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [23:0] sig;
    logic [55:0] wide;
    logic [31:0] mag;
    logic        frac;
    logic [5:0]  sh;
    logic [31:0] res;
    sgn  = bits[31];
    ex   = bits[30:23];
    man  = bits[22:0];
    sig  = {1'b1, man};
    wide = '0;
    mag  = '0;
    frac = 1'b0;
    sh   = '0;
    res  = '0;
    if (ex == 8'hFF && man != 23'd0) begin
      res = '0;
    end else if (ex >= 8'd127) begin
      res = sgn ? NegFull : PosFull;
    end else if (ex == 8'd0) begin
      // denormals and zeros: below 2^-31 magnitude
      res = (sgn && man != 23'd0) ? 32'hFFFF_FFFF : 32'd0;
    end else begin
      // value = sig * 2^(ex-150); times 2^31 -> sig * 2^(ex-119)
      if (ex >= 8'd119) begin
        sh  = 6'(ex - 8'd119);
        mag = 32'({8'd0, sig} << sh);
        frac = 1'b0;
      end else begin
        // tiny values keep the leading bit in the fraction so floor still sees it
        sh   = (ex < 8'd64) ? 6'd55 : 6'(8'd119 - ex);
        wide = {sig, 32'd0} >> sh;
        mag  = {8'd0, wide[55:32]};
        frac = (wide[31:0] != 32'd0);
      end
      res = sgn ? (32'(-mag) - {31'd0, frac}) : mag;
    end
    return res;
  endfunction

  // Signed 32-bit word times 2^-31 to single, round to nearest even.
  function automatic logic [31:0] word_to_float(input logic [31:0] w);
    logic        sgn;
    logic [31:0] mag;
    logic [4:0]  lz;
    logic [31:0] nrm;
    logic [24:0] rnd;
    logic        guard;
    logic        sticky;
    logic [7:0]  ex;
    logic [31:0] res;
    sgn = w[31];
    mag = sgn ? 32'(-w) : w;
    lz  = '0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) lz = 5'(31 - i);
    end
    nrm    = mag << lz;
    guard  = nrm[7];
    sticky = (nrm[6:0] != 7'd0);
    rnd    = {1'b0, nrm[31:8]} +
             {24'd0, guard && (sticky || nrm[8])};
    ex     = 8'(8'd127 - {3'd0, lz});
    if (rnd[24]) begin
      ex  = ex + 8'd1;
      rnd = rnd >> 1;
    end
    if (mag == 32'd0) res = '0;
    else res = {sgn, ex, rnd[22:0]};
    return res;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/pcm_sample_format_converter_top.sv
// Top level of the PCM sample format converter.
// One sample per cycle: a transfer is taken into an input register, converted by
// a single combinational pass (core), and held in a result register until its
// transfer out. Throughput is one sample per clock, set by the input and result
// register pair, which both advance whenever the result slot is free or being
// emptied. Write source_format (index 0) and target_format (index 1) only while
// no sample is in flight.
`default_nettype none
module pcm_sample_format_converter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [1:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] sample_in_i,
  input  wire logic        last_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [31:0] sample_out_o,
  output logic             last_out_o
);
  logic [1:0]  src_q, dst_q;
  logic        iv_q, ov_q;
  logic [31:0] is_q, os_q;
  logic        il_q, ol_q;
  logic [31:0] conv;
  logic        adv;

  // Advance the pipe when the result slot is empty or is being taken.
  assign adv        = !ov_q || out_ready_i;
  assign in_ready_o = adv || !iv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= pcm_cvt_pkg::FMT_FLOAT;
      dst_q <= pcm_cvt_pkg::FMT_FLOAT;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == pcm_cvt_pkg::REG_SOURCE_FORMAT) src_q <= cfg_data_i;
      else dst_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (in_ready_o) iv_q <= in_valid_i;
      if (adv) ov_q <= iv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      is_q <= sample_in_i;
      il_q <= last_in_i;
    end
    if (adv && iv_q) begin
      os_q <= conv;
      ol_q <= il_q;
    end
  end

  pcm_cvt_core u_core (
    .src_fmt_i (src_q),
    .dst_fmt_i (dst_q),
    .sample_i  (is_q),
    .sample_o  (conv)
  );

  assign out_valid_o  = ov_q;
  assign sample_out_o = os_q;
  assign last_out_o   = ol_q;

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(os_q)) else $error("result lost");
  // A full input stage moves on when the result slot frees.
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iv_q && adv |=> ov_q) else $error("item dropped");
  // Ready only when the input stage can take a sample.
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iv_q && ov_q && !out_ready_i |-> !in_ready_o) else $error("overrun");
endmodule
`default_nettype wire

### hw/rtl/pcm_cvt_core.sv
// Combinational conversion of one sample between formats.
`default_nettype none
module pcm_cvt_core (
  input  wire logic [1:0]  src_fmt_i,
  input  wire logic [1:0]  dst_fmt_i,
  input  wire logic [31:0] sample_i,
  output logic      [31:0] sample_o
);
  logic [31:0] s_masked;
  logic [31:0] word;
  logic [31:0] as_float;

  always_comb begin
    case (src_fmt_i)
      pcm_cvt_pkg::FMT_PCM8:  s_masked = {24'd0, sample_i[7:0]};
      pcm_cvt_pkg::FMT_PCM16: s_masked = {16'd0, sample_i[15:0]};
      pcm_cvt_pkg::FMT_PCM24: s_masked = {8'd0, sample_i[23:0]};
      default:                s_masked = sample_i;
    endcase
    case (src_fmt_i)
      pcm_cvt_pkg::FMT_PCM8:  word = {sample_i[7:0], 24'd0};
      pcm_cvt_pkg::FMT_PCM16: word = {sample_i[15:0], 16'd0};
      pcm_cvt_pkg::FMT_PCM24: word = {sample_i[23:0], 8'd0};
      default:                word = pcm_cvt_pkg::float_to_word(sample_i);
    endcase
    as_float = pcm_cvt_pkg::word_to_float(word);
    if (src_fmt_i == dst_fmt_i) begin
      sample_o = s_masked;
    end else begin
      case (dst_fmt_i)
        pcm_cvt_pkg::FMT_PCM8:  sample_o = {24'd0, word[31:24]};
        pcm_cvt_pkg::FMT_PCM16: sample_o = {16'd0, word[31:16]};
        pcm_cvt_pkg::FMT_PCM24: sample_o = {8'd0, word[31:8]};
        default:                sample_o = as_float;
      endcase
    end
  end
endmodule
`default_nettype wire
